// ----- hdl/i2c_register_master_unit_assert.svh -----
// assertion macros for the i2c register master checker
// no dependencies; included by the checker file
`ifndef I2C_REGISTER_MASTER_UNIT_ASSERT_SVH
`define I2C_REGISTER_MASTER_UNIT_ASSERT_SVH

// same-cycle implication under clk_i, off while in reset
`define I2CRM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("i2crm check failed");

// next-cycle implication under clk_i, off while in reset
`define I2CRM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("i2crm check failed");

`endif

// ----- hdl/i2crm_pkg.sv -----
// types and constants shared by the i2c register master
// no dependencies
package i2crm_pkg;

  localparam int unsigned AddrW   = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned BitIdxW = 4;

  localparam logic [AddrW-1:0] SensorAddrRst  = 7'd109;
  localparam logic [AddrW-1:0] DisplayAddrRst = 7'd62;
  localparam logic [BitIdxW-1:0] BitsPerByte  = 4'd8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SENSOR_ADDR  = 1'b0,
    CFG_DISPLAY_ADDR = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_BYTE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    OP_REG_WRITE   = 2'd0,
    OP_REG_READ    = 2'd1,
    OP_PLAIN_WRITE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ADDR_NACK = 2'd1,
    STAT_REG_NACK  = 2'd2,
    STAT_DATA_NACK = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    STG_ADDR  = 2'd0,
    STG_REG   = 2'd1,
    STG_DATA  = 2'd2,
    STG_RADDR = 2'd3
  } stage_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_TX_LOW    = 4'd3,
    PH_TX_HIGH   = 4'd4,
    PH_ACK_LOW   = 4'd5,
    PH_ACK_HIGH  = 4'd6,
    PH_WAIT      = 4'd7,
    PH_RX_LOW    = 4'd8,
    PH_RX_HIGH   = 4'd9,
    PH_MACK_LOW  = 4'd10,
    PH_MACK_HIGH = 4'd11,
    PH_STOP_A    = 4'd12,
    PH_STOP_B    = 4'd13,
    PH_STOP_C    = 4'd14
  } phase_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [1:0]       operation;
    logic             target;
    logic [ByteW-1:0] register_address;
    logic [ByteW-1:0] byte_count;
    logic [ByteW-1:0] write_byte;
    logic             sda_sample;
  } in_item_t;

  typedef struct packed {
    logic             scl_level;
    logic             sda_pull_low;
    logic [ByteW-1:0] read_byte;
    logic             read_valid;
    logic             byte_wanted;
    logic             busy_res;
    logic             done_res;
    logic [1:0]       status;
  } result_t;

endpackage

// ----- hdl/i2crm_if.sv -----
// valid/ready channel interfaces for command/tick items and result items
// no dependencies
interface i2crm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] operation;
  logic       target;
  logic [7:0] register_address;
  logic [7:0] byte_count;
  logic [7:0] write_byte;
  logic       sda_sample;

  modport source (output valid, kind, operation, target, register_address, byte_count,
                  write_byte, sda_sample, input ready);
  modport sink (input valid, kind, operation, target, register_address, byte_count,
                write_byte, sda_sample, output ready);
endinterface

interface i2crm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       byte_wanted;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;

  modport source (output valid, scl_level, sda_pull_low, read_byte, read_valid, byte_wanted,
                  busy_res, done_res, status, input ready);
  modport sink (input valid, scl_level, sda_pull_low, read_byte, read_valid, byte_wanted,
                busy_res, done_res, status, output ready);
endinterface

// ----- hdl/i2crm_core.sv -----
// bus phase sequencer: state registers, address registers and per-item next-state logic
// depends on i2crm_pkg
module i2crm_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [i2crm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [i2crm_pkg::AddrW-1:0]  cfg_data_i,
  input  logic                         accept_i,
  input  i2crm_pkg::in_item_t          item_i,
  output i2crm_pkg::result_t           res_o
);
  import i2crm_pkg::*;

  logic [AddrW-1:0]   sensor_addr_q, display_addr_q;
  phase_e             phase_q, phase_d;
  stage_e             stage_q, stage_d;
  logic [BitIdxW-1:0] bit_idx_q, bit_idx_d;
  logic [ByteW-1:0]   shift_q, shift_d;
  logic [ByteW-1:0]   left_q, left_d;
  op_e                op_q, op_d;
  logic               target_q, target_d;
  logic [ByteW-1:0]   reg_q, reg_d;
  status_e            stat_q, stat_d;
  logic               scl_q, scl_d;
  logic               pull_q, pull_d;

  logic [AddrW-1:0]   addr;
  logic [ByteW-1:0]   left_dec;
  logic [BitIdxW-1:0] bit_inc;
  logic [ByteW-1:0]   rx_shift;
  logic               rvalid;
  logic               done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_addr_q  <= SensorAddrRst;
      display_addr_q <= DisplayAddrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SENSOR_ADDR:  sensor_addr_q  <= cfg_data_i;
        CFG_DISPLAY_ADDR: display_addr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      stage_q   <= STG_ADDR;
      bit_idx_q <= '0;
      shift_q   <= '0;
      left_q    <= '0;
      op_q      <= OP_REG_WRITE;
      target_q  <= 1'b0;
      reg_q     <= '0;
      stat_q    <= STAT_OK;
      scl_q     <= 1'b1;
      pull_q    <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      stage_q   <= stage_d;
      bit_idx_q <= bit_idx_d;
      shift_q   <= shift_d;
      left_q    <= left_d;
      op_q      <= op_d;
      target_q  <= target_d;
      reg_q     <= reg_d;
      stat_q    <= stat_d;
      scl_q     <= scl_d;
      pull_q    <= pull_d;
    end
  end

  assign addr     = target_q ? display_addr_q : sensor_addr_q;
  assign left_dec = left_q - 8'd1;
  assign bit_inc  = bit_idx_q + 4'd1;
  assign rx_shift = {shift_q[ByteW-2:0], item_i.sda_sample};

  always_comb begin
    phase_d   = phase_q;
    stage_d   = stage_q;
    bit_idx_d = bit_idx_q;
    shift_d   = shift_q;
    left_d    = left_q;
    op_d      = op_q;
    target_d  = target_q;
    reg_d     = reg_q;
    stat_d    = stat_q;
    scl_d     = scl_q;
    pull_d    = pull_q;
    rvalid    = 1'b0;
    done      = 1'b0;
    case (kind_e'(item_i.kind))
      KIND_CMD: begin
        if (phase_q == PH_IDLE && item_i.operation != 2'd3) begin
          op_d     = op_e'(item_i.operation);
          target_d = item_i.target;
          reg_d    = item_i.register_address;
          left_d   = item_i.byte_count;
          stat_d   = STAT_OK;
          stage_d  = STG_ADDR;
          phase_d  = PH_START_A;
        end
      end
      KIND_BYTE: begin
        if (phase_q == PH_WAIT) begin
          shift_d   = item_i.write_byte;
          stage_d   = STG_DATA;
          bit_idx_d = '0;
          phase_d   = PH_TX_LOW;
        end
      end
      KIND_TICK: begin
        case (phase_q)
          PH_START_A: begin
            scl_d = 1'b1; pull_d = 1'b0; phase_d = PH_START_B;
          end
          PH_START_B: begin
            scl_d     = 1'b1;
            pull_d    = 1'b1;
            bit_idx_d = '0;
            phase_d   = PH_TX_LOW;
            if (stage_q == STG_RADDR) begin
              shift_d = {addr, 1'b1};
            end else begin
              shift_d = {addr, 1'b0};
              stage_d = STG_ADDR;
            end
          end
          PH_TX_LOW: begin
            scl_d = 1'b0; pull_d = ~shift_q[ByteW-1]; phase_d = PH_TX_HIGH;
          end
          PH_TX_HIGH: begin
            scl_d     = 1'b1;
            pull_d    = ~shift_q[ByteW-1];
            shift_d   = {shift_q[ByteW-2:0], 1'b0};
            bit_idx_d = bit_inc;
            phase_d   = (bit_inc >= BitsPerByte) ? PH_ACK_LOW : PH_TX_LOW;
          end
          PH_ACK_LOW: begin
            scl_d = 1'b0; pull_d = 1'b0; phase_d = PH_ACK_HIGH;
          end
          PH_ACK_HIGH: begin
            scl_d  = 1'b1;
            pull_d = 1'b0;
            if (item_i.sda_sample) begin
              case (stage_q)
                STG_REG:  stat_d = STAT_REG_NACK;
                STG_DATA: stat_d = STAT_DATA_NACK;
                default:  stat_d = STAT_ADDR_NACK;
              endcase
              phase_d = PH_STOP_A;
            end else begin
              case (stage_q)
                STG_ADDR: begin
                  if (op_q == OP_PLAIN_WRITE) begin
                    phase_d = (left_q == '0) ? PH_STOP_A : PH_WAIT;
                  end else begin
                    shift_d   = reg_q;
                    stage_d   = STG_REG;
                    bit_idx_d = '0;
                    phase_d   = PH_TX_LOW;
                  end
                end
                STG_REG: begin
                  if (op_q == OP_REG_READ) begin
                    phase_d = PH_STOP_A;
                  end else begin
                    phase_d = (left_q == '0) ? PH_STOP_A : PH_WAIT;
                  end
                end
                STG_DATA: begin
                  left_d  = left_dec;
                  phase_d = (left_dec == '0) ? PH_STOP_A : PH_WAIT;
                end
                default: begin
                  bit_idx_d = '0;
                  shift_d   = '0;
                  phase_d   = (left_q == '0) ? PH_STOP_A : PH_RX_LOW;
                end
              endcase
            end
          end
          PH_WAIT: begin
            scl_d = 1'b0; pull_d = 1'b0;
          end
          PH_RX_LOW: begin
            scl_d = 1'b0; pull_d = 1'b0; phase_d = PH_RX_HIGH;
          end
          PH_RX_HIGH: begin
            scl_d     = 1'b1;
            pull_d    = 1'b0;
            shift_d   = rx_shift;
            bit_idx_d = bit_inc;
            if (bit_inc >= BitsPerByte) begin
              rvalid  = 1'b1;
              left_d  = left_dec;
              phase_d = PH_MACK_LOW;
            end else begin
              phase_d = PH_RX_LOW;
            end
          end
          PH_MACK_LOW: begin
            scl_d = 1'b0; pull_d = (left_q != '0); phase_d = PH_MACK_HIGH;
          end
          PH_MACK_HIGH: begin
            scl_d     = 1'b1;
            pull_d    = (left_q != '0);
            bit_idx_d = '0;
            shift_d   = '0;
            phase_d   = (left_q != '0) ? PH_RX_LOW : PH_STOP_A;
          end
          PH_STOP_A: begin
            scl_d = 1'b0; pull_d = 1'b1; phase_d = PH_STOP_B;
          end
          PH_STOP_B: begin
            scl_d = 1'b1; pull_d = 1'b1; phase_d = PH_STOP_C;
          end
          PH_STOP_C: begin
            scl_d  = 1'b1;
            pull_d = 1'b0;
            // restart between register byte and read address
            if (stage_q == STG_REG && op_q == OP_REG_READ && stat_q == STAT_OK) begin
              stage_d = STG_RADDR;
              phase_d = PH_START_A;
            end else begin
              done    = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          PH_IDLE: ;
          default: begin
            scl_d = 1'b1; pull_d = 1'b0; phase_d = PH_IDLE;
          end
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    res_o.scl_level    = scl_d;
    res_o.sda_pull_low = pull_d;
    res_o.read_byte    = rvalid ? rx_shift : '0;
    res_o.read_valid   = rvalid;
    res_o.byte_wanted  = (phase_d == PH_WAIT);
    res_o.busy_res     = (phase_d != PH_IDLE);
    res_o.done_res     = done;
    res_o.status       = stat_d;
  end

endmodule

// ----- hdl/i2crm_outq.sv -----
// two-entry result queue between the sequencer and the result channel
// depends on i2crm_pkg
module i2crm_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  i2crm_pkg::result_t data_i,
  output logic               space_o,
  output logic               valid_o,
  input  logic               pop_i,
  output i2crm_pkg::result_t data_o
);
  import i2crm_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign space_o = (count_q != 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

// ----- hdl/i2c_register_master_unit.sv -----
// top level of the i2c register master: sequencer plus result queue
// depends on i2crm_pkg, i2crm_if, i2crm_core, i2crm_outq
//
// in_i carries items: ticks (one half-bit bus phase each, with the sampled
// sda level), commands (register write, register read, plain write) and
// write bytes supplied when byte_wanted is shown. out_o carries exactly one
// result per item: the scl/sda levels to drive, a received byte, status.
// each result is written into the result queue when its item is taken.
// throughput: one item per cycle while the queue has space; the whole
// phase update is one pass of logic from state registers to result queue.
// a two-entry result queue decouples the sides, so in_i.ready stays high
// while one result waits; it drops only once two results are stalled.
// cfg_we_i writes the target bus addresses (index 0 sensor, 1 display);
// write only while no item is pending.
// reset: bus idle, scl high, sda released, addresses 109 and 62, queue empty.
module i2c_register_master_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [i2crm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [i2crm_pkg::AddrW-1:0]   cfg_data_i,
  i2crm_in_if.sink                      in_i,
  i2crm_out_if.source                   out_o
);
  import i2crm_pkg::*;

  in_item_t item;
  result_t  res;
  result_t  head;
  logic     space;
  logic     accept;

  assign item.kind             = in_i.kind;
  assign item.operation        = in_i.operation;
  assign item.target           = in_i.target;
  assign item.register_address = in_i.register_address;
  assign item.byte_count       = in_i.byte_count;
  assign item.write_byte       = in_i.write_byte;
  assign item.sda_sample       = in_i.sda_sample;

  assign in_i.ready = space;
  assign accept     = in_i.valid & space;

  i2crm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .item_i      (item),
    .res_o       (res)
  );

  i2crm_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .space_o (space),
    .valid_o (out_o.valid),
    .pop_i   (out_o.valid & out_o.ready),
    .data_o  (head)
  );

  assign out_o.scl_level    = head.scl_level;
  assign out_o.sda_pull_low = head.sda_pull_low;
  assign out_o.read_byte    = head.read_byte;
  assign out_o.read_valid   = head.read_valid;
  assign out_o.byte_wanted  = head.byte_wanted;
  assign out_o.busy_res     = head.busy_res;
  assign out_o.done_res     = head.done_res;
  assign out_o.status       = head.status;

endmodule

// ----- hdl/i2crm_checker.sv -----
// port-level checks on the result channel of the i2c register master
// depends on i2c_register_master_unit_assert.svh; bound to the top level
`include "i2c_register_master_unit_assert.svh"

module i2crm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       ready_i,
  input logic [7:0] read_byte_i,
  input logic       read_valid_i,
  input logic       byte_wanted_i,
  input logic       busy_res_i,
  input logic       done_res_i
);
  `I2CRM_ASSERT_IMP(a_done_idle, valid_i && done_res_i, !busy_res_i && !byte_wanted_i)
  `I2CRM_ASSERT_IMP(a_read_busy, valid_i && read_valid_i, busy_res_i && !done_res_i)
  `I2CRM_ASSERT_IMP(a_read_zero, valid_i && !read_valid_i, read_byte_i == 8'd0)
  `I2CRM_ASSERT_NEXT(a_hold, valid_i && !ready_i, valid_i && $stable(read_byte_i))
endmodule

bind i2c_register_master_unit i2crm_checker u_i2crm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (out_o.valid),
  .ready_i       (out_o.ready),
  .read_byte_i   (out_o.read_byte),
  .read_valid_i  (out_o.read_valid),
  .byte_wanted_i (out_o.byte_wanted),
  .busy_res_i    (out_o.busy_res),
  .done_res_i    (out_o.done_res)
);
